FILE: rtl/core/hjb_pkg.sv
// Shared types, constants and codes of the joint histogram binner.
`timescale 1ns / 1ps
package hjb_pkg;

	localparam int MAX_BINS_X_DEF  = 256;
	localparam int MAX_BINS_Y_DEF  = 256;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int BINS_W       = 9;   // width of a bin count register
	localparam int QUO_W        = 9;   // quotient bits, nb - 1 < 2**9
	localparam int DIFF_W       = 33;  // difference of two Q16.16 values
	localparam int NUM_W        = DIFF_W + BINS_W;
	localparam int STORE_AW_MAX = 24;  // address bits carried in an entry
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BINS_X    = 3'd0,
		REG_BINS_Y    = 3'd1,
		REG_X_MIN     = 3'd2,
		REG_X_MAX     = 3'd3,
		REG_Y_MIN     = 3'd4,
		REG_Y_MAX     = 3'd5,
		REG_SKIP_MASK = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [BINS_W-1:0] bins_x;
		logic [BINS_W-1:0] bins_y;
		logic signed [31:0] x_min;
		logic signed [31:0] x_max;
		logic signed [31:0] y_min;
		logic signed [31:0] y_max;
		logic [7:0]         skip_mask;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		bins_x:    9'd256,
		bins_y:    9'd256,
		x_min:     32'sd0,
		x_max:     32'sd65536,
		y_min:     32'sd0,
		y_max:     32'sd65536,
		skip_mask: 8'd0
	};

	// one classified item on its way from front to back
	typedef struct packed {
		op_t                     op;
		logic [7:0]              bin_x;
		logic [7:0]              bin_y;
		logic                    inc;
		logic                    in_range;
		logic [STORE_AW_MAX-1:0] addr;
	} entry_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_SUB,
		F_MUL,
		F_DIV,
		F_IDX,
		F_PUSH
	} f_state_t;

	typedef enum logic [1:0] {
		B_INIT,
		B_IDLE,
		B_RMW,
		B_CLEAR
	} b_state_t;

	typedef struct packed {
		logic init_busy;
	} bstat_t;

endpackage

FILE: rtl/core/hjb_in_if.sv
// Input channel of the joint histogram binner.
`timescale 1ns / 1ps
interface hjb_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic [7:0]         ghost_flags;
	logic [15:0]        bin_index;

	modport source(output valid, operation, value_x, value_y, ghost_flags, bin_index,
		input ready);
	modport sink(input valid, operation, value_x, value_y, ghost_flags, bin_index,
		output ready);
endinterface

FILE: rtl/core/hjb_out_if.sv
// Result channel of the joint histogram binner.
`timescale 1ns / 1ps
interface hjb_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  bin_x;
	logic [7:0]  bin_y;
	logic        counted;
	logic [31:0] bin_count;

	modport source(output valid, bin_x, bin_y, counted, bin_count, input ready);
	modport sink(input valid, bin_x, bin_y, counted, bin_count, output ready);
endinterface

FILE: rtl/core/hjb_ram.sv
// Generic RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module hjb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/hjb_queue.sv
// Two-entry queue between the classifying front and the store back end.
`timescale 1ns / 1ps
module hjb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hjb_pkg::entry_t din,
	input  logic           pop,
	output logic           valid,
	output logic           full,
	output hjb_pkg::entry_t dout
);
	import hjb_pkg::*;

	entry_t     slot_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = slot_q[rd_q];
endmodule

FILE: rtl/core/hjb_front.sv
// Front end: accepts items, bins samples with a restoring divider per axis.
`timescale 1ns / 1ps
module hjb_front #(
	parameter int MAX_BINS_X = hjb_pkg::MAX_BINS_X_DEF,
	parameter int MAX_BINS_Y = hjb_pkg::MAX_BINS_Y_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hjb_pkg::cfg_t  cfg,
	input  hjb_pkg::bstat_t bstat,
	hjb_in_if.sink         sample_in,
	input  logic           q_full,
	output logic           q_push,
	output hjb_pkg::entry_t q_din
);
	import hjb_pkg::*;

	localparam int DEPTH  = MAX_BINS_X * MAX_BINS_Y;
	localparam int STEP_W = $clog2(QUO_W);

	f_state_t state_q, state_nx;

	logic signed [31:0] vx_q, vy_q;
	logic [7:0]         flags_q;
	entry_t             ent_q;
	logic [STEP_W-1:0]  step_q;

	logic [DIFF_W-1:0] d_q    [2];
	logic [DIFF_W-1:0] rng_q  [2];
	logic              zero_q [2];
	logic              top_q  [2];
	logic [NUM_W-1:0]  rem_q  [2];
	logic [QUO_W-1:0]  quo_q  [2];

	logic [BINS_W-1:0] nb   [2];
	logic [BINS_W-1:0] nbm1 [2];
	logic signed [DIFF_W-1:0] rng_s [2];
	logic signed [DIFF_W-1:0] d_s   [2];
	logic [NUM_W-1:0]  div_sh [2];
	logic [BINS_W-1:0] bin_f  [2];
	logic [2*BINS_W-1:0] flat;
	logic accept;

	// bin count registers: zero counts as one, large values cap at the grid size
	always_comb begin
		if (cfg.bins_x == '0) begin
			nb[0] = BINS_W'(1);
		end else if (32'(cfg.bins_x) > MAX_BINS_X) begin
			nb[0] = BINS_W'(MAX_BINS_X);
		end else begin
			nb[0] = cfg.bins_x;
		end
		if (cfg.bins_y == '0) begin
			nb[1] = BINS_W'(1);
		end else if (32'(cfg.bins_y) > MAX_BINS_Y) begin
			nb[1] = BINS_W'(MAX_BINS_Y);
		end else begin
			nb[1] = cfg.bins_y;
		end
		nbm1[0] = nb[0] - BINS_W'(1);
		nbm1[1] = nb[1] - BINS_W'(1);
	end

	always_comb begin
		rng_s[0] = {cfg.x_max[31], cfg.x_max} - {cfg.x_min[31], cfg.x_min};
		rng_s[1] = {cfg.y_max[31], cfg.y_max} - {cfg.y_min[31], cfg.y_min};
		d_s[0]   = {vx_q[31], vx_q} - {cfg.x_min[31], cfg.x_min};
		d_s[1]   = {vy_q[31], vy_q} - {cfg.y_min[31], cfg.y_min};
		for (int k = 0; k < 2; k++) begin
			div_sh[k] = {{BINS_W{1'b0}}, rng_q[k]} << step_q;
			if (zero_q[k]) begin
				bin_f[k] = '0;
			end else if (top_q[k]) begin
				bin_f[k] = nbm1[k];
			end else begin
				bin_f[k] = quo_q[k];
			end
		end
		flat = ({{BINS_W{1'b0}}, bin_f[1]} * {{BINS_W{1'b0}}, nb[0]})
			+ {{BINS_W{1'b0}}, bin_f[0]};
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_nx = (op_t'(sample_in.operation) == OP_ADD) ? F_SUB : F_PUSH;
				end
			end
			F_SUB:  state_nx = F_MUL;
			F_MUL:  state_nx = F_DIV;
			F_DIV: begin
				if (step_q == '0) begin
					state_nx = F_IDX;
				end
			end
			F_IDX:  state_nx = F_PUSH;
			F_PUSH: begin
				if (!q_full) begin
					state_nx = F_IDLE;
				end
			end
			default: state_nx = F_IDLE;
		endcase
	end

	always_comb begin
		sample_in.ready = (state_q == F_IDLE) && !bstat.init_busy;
		q_push          = (state_q == F_PUSH) && !q_full;
	end

	assign accept = sample_in.valid && sample_in.ready;
	assign q_din  = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					vx_q          <= sample_in.value_x;
					vy_q          <= sample_in.value_y;
					flags_q       <= sample_in.ghost_flags;
					ent_q.op      <= op_t'(sample_in.operation);
					ent_q.bin_x   <= '0;
					ent_q.bin_y   <= '0;
					ent_q.inc     <= 1'b0;
					ent_q.in_range <= ({16'd0, sample_in.bin_index} < 32'(DEPTH));
					ent_q.addr    <= STORE_AW_MAX'(sample_in.bin_index);
				end
			end
			F_SUB: begin
				for (int k = 0; k < 2; k++) begin
					d_q[k]    <= d_s[k];
					rng_q[k]  <= rng_s[k];
					zero_q[k] <= (rng_s[k] <= 0) || (d_s[k] <= 0);
					top_q[k]  <= (d_s[k] >= rng_s[k]);
				end
			end
			F_MUL: begin
				for (int k = 0; k < 2; k++) begin
					rem_q[k] <= {{BINS_W{1'b0}}, d_q[k]} * {{DIFF_W{1'b0}}, nbm1[k]};
					quo_q[k] <= '0;
				end
				step_q <= STEP_W'(QUO_W - 1);
			end
			F_DIV: begin
				// one quotient bit per cycle, most significant first
				for (int k = 0; k < 2; k++) begin
					if (rem_q[k] >= div_sh[k]) begin
						rem_q[k]         <= rem_q[k] - div_sh[k];
						quo_q[k][step_q] <= 1'b1;
					end
				end
				step_q <= step_q - STEP_W'(1);
			end
			F_IDX: begin
				ent_q.bin_x    <= bin_f[0][7:0];
				ent_q.bin_y    <= bin_f[1][7:0];
				ent_q.inc      <= ((flags_q & cfg.skip_mask) == 8'd0);
				ent_q.in_range <= 1'b1;
				ent_q.addr     <= STORE_AW_MAX'(flat);
			end
			default: ;
		endcase
	end
endmodule

FILE: rtl/core/hjb_back.sv
// Back end: read-modify-write of the count store, clearing sweeps, result register.
`timescale 1ns / 1ps
module hjb_back #(
	parameter int MAX_BINS_X  = hjb_pkg::MAX_BINS_X_DEF,
	parameter int MAX_BINS_Y  = hjb_pkg::MAX_BINS_Y_DEF,
	parameter int COUNT_WIDTH = hjb_pkg::COUNT_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  hjb_pkg::entry_t q_dout,
	output logic            q_pop,
	output hjb_pkg::bstat_t bstat,
	hjb_out_if.source       result_out
);
	import hjb_pkg::*;

	localparam int DEPTH = MAX_BINS_X * MAX_BINS_Y;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	b_state_t state_q, state_nx;

	logic [AW-1:0]          sweep_q;
	entry_t                 ent_q;
	logic                   ovalid_q;
	logic [7:0]             obx_q, oby_q;
	logic                   ocnt_q;
	logic [31:0]            obin_q;

	logic                   out_free;
	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata, new_cnt;
	logic                   bump;

	hjb_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(q_dout.addr)),
		.rdata (ram_rdata)
	);

	assign out_free = !ovalid_q || result_out.ready;
	assign bump     = (ent_q.op == OP_ADD) && ent_q.inc && (ram_rdata != '1);
	assign new_cnt  = bump ? ram_rdata + COUNT_WIDTH'(1) : ram_rdata;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_INIT: begin
				if (sweep_q == LAST) begin
					state_nx = B_IDLE;
				end
			end
			B_IDLE: begin
				if (q_valid && out_free) begin
					case (q_dout.op)
						OP_ADD, OP_READ: state_nx = B_RMW;
						OP_CLEAR:        state_nx = B_CLEAR;
						default:         state_nx = B_IDLE;
					endcase
				end
			end
			B_RMW: state_nx = B_IDLE;
			B_CLEAR: begin
				if (sweep_q == LAST) begin
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop           = (state_q == B_IDLE) && q_valid && out_free;
		ram_re          = q_pop && q_dout.in_range
			&& ((q_dout.op == OP_ADD) || (q_dout.op == OP_READ));
		ram_we          = 1'b0;
		ram_waddr       = sweep_q;
		ram_wdata       = '0;
		bstat.init_busy = (state_q == B_INIT);
		case (state_q)
			B_INIT, B_CLEAR: ram_we = 1'b1;
			B_RMW: begin
				ram_we    = bump;
				ram_waddr = AW'(ent_q.addr);
				ram_wdata = new_cnt;
			end
			default: ;
		endcase
	end

	assign result_out.valid     = ovalid_q;
	assign result_out.bin_x     = obx_q;
	assign result_out.bin_y     = oby_q;
	assign result_out.counted   = ocnt_q;
	assign result_out.bin_count = obin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_INIT;
			sweep_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if ((state_q == B_INIT) || (state_q == B_CLEAR)) begin
				sweep_q <= (sweep_q == LAST) ? '0 : sweep_q + AW'(1);
			end
			if ((q_pop && (q_dout.op == OP_NOP)) || (state_q == B_RMW)
				|| ((state_q == B_CLEAR) && (sweep_q == LAST))) begin
				ovalid_q <= 1'b1;
			end else if (result_out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_dout;
		end
		if (q_pop && (q_dout.op == OP_NOP)) begin
			obx_q  <= '0;
			oby_q  <= '0;
			ocnt_q <= 1'b0;
			obin_q <= '0;
		end else if (state_q == B_RMW) begin
			obx_q  <= ent_q.bin_x;
			oby_q  <= ent_q.bin_y;
			ocnt_q <= ent_q.inc && (ent_q.op == OP_ADD);
			obin_q <= ent_q.in_range ? 32'(new_cnt) : 32'd0;
		end else if ((state_q == B_CLEAR) && (sweep_q == LAST)) begin
			obx_q  <= '0;
			oby_q  <= '0;
			ocnt_q <= 1'b0;
			obin_q <= '0;
		end
	end
endmodule

FILE: rtl/core/joint_histogram_2d_binner.sv
// Joint 2D histogram binner: top level with configuration registers.
//
// sample_in carries one item per valid/ready handshake: add a sample, read one
// bin, clear the whole store or do nothing. result_out returns exactly one
// item for each input item, in order, over valid/ready.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, one register a
// cycle. The user must write it only while the block is idle; the block itself
// does not enforce this. In the front a sample passes through subtract,
// multiply, nine divider steps, flat index and hand-off; in the back come the
// store read, then increment and write. The front takes no new item until the
// current one has been handed to the queue. A read skips the arithmetic and
// goes straight to the hand-off. A clear sweeps the whole store. After reset
// the same sweep runs first; sample_in.ready stays low until it ends.
// Registers take their reset values at once. A two-entry queue parts front and
// back, and the result sits in an output register: when the receiver stalls,
// the back end holds, the queue fills and only then does the front stop taking
// items.
`timescale 1ns / 1ps
module joint_histogram_2d_binner #(
	parameter int MAX_BINS_X  = hjb_pkg::MAX_BINS_X_DEF,
	parameter int MAX_BINS_Y  = hjb_pkg::MAX_BINS_Y_DEF,
	parameter int COUNT_WIDTH = hjb_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hjb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hjb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	hjb_in_if.sink                         sample_in,
	hjb_out_if.source                      result_out
);
	import hjb_pkg::*;

	cfg_t   cfg_q;
	bstat_t bstat;
	entry_t q_din, q_dout;
	logic   q_push, q_pop, q_valid, q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BINS_X:    cfg_q.bins_x    <= cfg_wdata[BINS_W-1:0];
				REG_BINS_Y:    cfg_q.bins_y    <= cfg_wdata[BINS_W-1:0];
				REG_X_MIN:     cfg_q.x_min     <= cfg_wdata;
				REG_X_MAX:     cfg_q.x_max     <= cfg_wdata;
				REG_Y_MIN:     cfg_q.y_min     <= cfg_wdata;
				REG_Y_MAX:     cfg_q.y_max     <= cfg_wdata;
				REG_SKIP_MASK: cfg_q.skip_mask <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	hjb_front #(
		.MAX_BINS_X (MAX_BINS_X),
		.MAX_BINS_Y (MAX_BINS_Y)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.bstat     (bstat),
		.sample_in (sample_in),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_din     (q_din)
	);

	hjb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.valid  (q_valid),
		.full   (q_full),
		.dout   (q_dout)
	);

	hjb_back #(
		.MAX_BINS_X  (MAX_BINS_X),
		.MAX_BINS_Y  (MAX_BINS_Y),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_dout     (q_dout),
		.q_pop      (q_pop),
		.bstat      (bstat),
		.result_out (result_out)
	);

`ifndef ASSERT_OFF
	a_no_item_during_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.init_busy |-> !(sample_in.valid && sample_in.ready))
		else $error("item taken during store sweep");

	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.counted) |-> (result_out.bin_count != 32'd0))
		else $error("counted sample reports a zero count");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue pushed while full");
`endif
endmodule
